/* src/scld_pkg.sv */
// Shared types, constants and character helpers for the serial command line decoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package scld_pkg;

    localparam int BUFFER_BYTES   = 10;
    localparam int MAX_HEX_DIGITS = 4;

    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam int IDX_W = $clog2(BUFFER_BYTES);

    localparam int          CALIB_LEN = 6;
    localparam logic [47:0] KW_CALIB  = "callib";
    localparam int          GOTO_LEN  = 5;
    localparam logic [39:0] KW_GOTO   = "goto ";
    localparam int          HEX_START = GOTO_LEN + 2;

    localparam logic [7:0] CH_ZERO = "0";
    localparam logic [7:0] CH_NINE = "9";
    localparam logic [7:0] CH_X    = "x";
    localparam logic [7:0] CH_A    = "A";
    localparam logic [7:0] CH_F    = "F";

    typedef enum logic [1:0] {
        CMD_NONE      = 2'd0,
        CMD_CALIBRATE = 2'd1,
        CMD_GOTO      = 2'd2
    } cmd_t;

    typedef logic [BUFFER_BYTES-1:0][7:0] line_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             overflow;
        logic             fire;
    } line_stat_t;

    typedef struct packed {
        logic        overflowed;
        logic        position_ok;
        logic [15:0] position;
        cmd_t        command;
    } result_t;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= CH_A) && (c <= CH_F)) || ((c >= CH_ZERO) && (c <= CH_NINE));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        if ((c >= CH_A) && (c <= CH_F)) begin
            d = c - CH_A + 8'd10;
        end else begin
            d = c - CH_ZERO;
        end
        return d[3:0];
    endfunction

endpackage
`default_nettype wire

/* src/serial_command_line_decoder.sv */
// Serial command line decoder: a terminator request is accepted into the input
// register, then the decoded result is captured in the result register.
// Throughput is one byte per cycle; input keeps flowing while a result waits,
// and stalls only when a terminator meets a result not yet taken.
// Reset (aresetn low, synchronous) clears count, overflow flag, valids and the
// terminator (NUL); line buffer contents are not cleared.
`default_nettype none
module serial_command_line_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,   // [7:0] terminator_char
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata     // [1:0] command, [17:2] position,
                                         // [18] position_ok, [19] overflowed
);
    import scld_pkg::*;

    logic       [7:0] term_reg;
    logic             m_valid_reg, m_valid_next;
    result_t          m_data_reg;
    result_t          res;
    line_t            line;
    line_stat_t       stat;
    logic             out_free;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    scld_line_buffer u_line (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .term     (term_reg),
        .out_free (out_free),
        .line     (line),
        .stat     (stat)
    );

    scld_classify u_classify (
        .line (line),
        .stat (stat),
        .res  (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (stat.fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_reg    <= 8'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                term_reg <= cfg_data;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stat.fire) begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_data_reg};

`ifndef SYNTH
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a pending result");
    a_ok_is_goto: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_data_reg.position_ok |-> m_data_reg.command == CMD_GOTO)
        else $error("position valid on a non-goto line");
    a_ok_no_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_data_reg.position_ok |-> !m_data_reg.overflowed)
        else $error("position valid on an overflowed line");
    a_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_data_reg.position_ok |-> m_data_reg.position == 16'd0)
        else $error("nonzero position without valid argument");
`endif
endmodule
`default_nettype wire

/* src/scld_line_buffer.sv */
// Input register, line buffer, character count and overflow flag.
// Depends on scld_pkg.
`default_nettype none
module scld_line_buffer (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // [7:0] rx_byte
    input  wire logic [7:0]         term,
    input  wire logic               out_free,
    output scld_pkg::line_t         line,
    output scld_pkg::line_stat_t    stat
);
    import scld_pkg::*;

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    line_t            buf_reg;
    logic             is_term, consume, store;

    assign is_term  = in_byte_reg == term;
    assign consume  = in_valid_reg && (!is_term || out_free);
    assign s_tready = !in_valid_reg || consume;
    assign store    = consume && !is_term && (count_reg < CNT_W'(BUFFER_BYTES));

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (consume) begin
            if (is_term) begin
                count_next = '0;
                ovf_next   = 1'b0;
            end else if (store) begin
                count_next = count_reg + CNT_W'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (store) begin
            buf_reg[count_reg[IDX_W-1:0]] <= in_byte_reg;
        end
    end

    assign line       = buf_reg;
    assign stat.count    = count_reg;
    assign stat.overflow = ovf_reg;
    assign stat.fire     = consume && is_term;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(BUFFER_BYTES))
        else $error("character count beyond buffer size");
    a_clear_on_term: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.fire |=> (count_reg == '0) && !ovf_reg)
        else $error("line state not cleared after terminator");
    a_ovf_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && !is_term && !store |-> count_reg == CNT_W'(BUFFER_BYTES))
        else $error("byte dropped while buffer not full");
`endif
endmodule
`default_nettype wire

/* src/scld_classify.sv */
// Keyword match and hex argument parse over the stored line.
// Depends on scld_pkg; purely combinational.
`default_nettype none
module scld_classify (
    input  scld_pkg::line_t       line,
    input  scld_pkg::line_stat_t  stat,
    output scld_pkg::result_t     res
);
    import scld_pkg::*;

    logic        calib_hit, goto_hit, hex_ok, chars_ok;
    logic [15:0] value;

    always_comb begin
        calib_hit = stat.count >= CNT_W'(CALIB_LEN);
        for (int i = 0; i < CALIB_LEN; i++) begin
            if (line[i] != KW_CALIB[8*(CALIB_LEN-1-i) +: 8]) begin
                calib_hit = 1'b0;
            end
        end
        goto_hit = stat.count >= CNT_W'(GOTO_LEN);
        for (int i = 0; i < GOTO_LEN; i++) begin
            if (line[i] != KW_GOTO[8*(GOTO_LEN-1-i) +: 8]) begin
                goto_hit = 1'b0;
            end
        end

        chars_ok = 1'b1;
        for (int i = HEX_START; i < BUFFER_BYTES; i++) begin
            if ((CNT_W'(i) < stat.count) && !is_hex(line[i])) begin
                chars_ok = 1'b0;
            end
        end
        hex_ok = (stat.count > CNT_W'(HEX_START))
              && (stat.count <= CNT_W'(HEX_START + MAX_HEX_DIGITS))
              && (line[GOTO_LEN] == CH_ZERO) && (line[GOTO_LEN+1] == CH_X)
              && chars_ok && !stat.overflow;

        value = '0;
        for (int k = 0; (k < MAX_HEX_DIGITS) && (HEX_START + k < BUFFER_BYTES); k++) begin
            if (CNT_W'(HEX_START + k) < stat.count) begin
                value = {value[11:0], hex_val(line[HEX_START + k])};
            end
        end

        res.overflowed  = stat.overflow;
        res.position_ok = 1'b0;
        res.position    = '0;
        if (calib_hit) begin
            res.command = CMD_CALIBRATE;
        end else if (goto_hit) begin
            res.command = CMD_GOTO;
            if (hex_ok) begin
                res.position_ok = 1'b1;
                res.position    = value;
            end
        end else begin
            res.command = CMD_NONE;
        end
    end
endmodule
`default_nettype wire
